[design/spr_pkg.sv]
// Shared types and codes of the shortest prefix word replacer.
`default_nettype none
package spr_pkg;

  // Input action codes
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_TEXT  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;   // take a dictionary character
    logic clear;  // empty the dictionary
    logic text;   // capture a text character, start its scan
    logic issue;  // read the next dictionary entry
    logic emit;   // load the output register, update word state
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic replaced;   // current text word already matched
    logic need_scan;  // position in range and dictionary not empty
    logic more;       // entries left to read
    logic pend;       // a read is in flight, compare this cycle
    logic out_free;   // output register can take a beat
  } status_t;

endpackage
`default_nettype wire

[design/spr_ifs.sv]
// Valid/ready channel interfaces for input characters and output beats.
`default_nettype none
interface spr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, input ready, output action, output ch, output last);
  modport sink (input valid, output ready, input action, input ch, input last);
endinterface

interface spr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic       word_end;

  modport source (output valid, input ready, output out_char, output char_valid,
                  output word_end);
  modport sink (input valid, output ready, input out_char, input char_valid,
                input word_end);
endinterface
`default_nettype wire

[design/spr_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none
module spr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[design/spr_ctrl.sv]
// Controller state machine: accepts characters, steps the entry scan, emits.
`default_nettype none
module spr_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic [1:0]       action,
  input  wire logic             last,
  input  wire spr_pkg::status_t st,
  output spr_pkg::cmd_t         cmd,
  output logic                  in_ready
);
  import spr_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (action)
            ACT_LOAD:  cmd.load  = 1'b1;
            ACT_CLEAR: cmd.clear = 1'b1;
            ACT_TEXT: begin
              cmd.text = 1'b1;
              if (st.replaced) begin
                // suppressed characters give nothing; the last gives the end marker
                if (last) state_next = ST_EMIT;
              end else if (st.need_scan) begin
                state_next = ST_SCAN;
              end else begin
                state_next = ST_EMIT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (st.more) begin
          cmd.issue = 1'b1;
        end else if (!st.pend) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

[design/spr_dp.sv]
// Datapath: dictionary memories, alive mask, word state and output register.
`default_nettype none
module spr_dp #(
  parameter int ENTRIES = 16,
  parameter int MAX_LEN = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [7:0]  ch,
  input  wire logic        last,
  input  wire spr_pkg::cmd_t cmd,
  output spr_pkg::status_t st,
  spr_out_if.source        dout
);
  import spr_pkg::*;

  localparam int CW    = $clog2(ENTRIES + 1);
  localparam int EW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int LPW   = $clog2(MAX_LEN + 2);
  localparam int TPW   = $clog2(MAX_LEN + 1);
  localparam int DEPTH = ENTRIES * MAX_LEN;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = $clog2(DEPTH + 1) + 1;

  // dictionary state
  logic [CW-1:0]      count;
  logic [LPW-1:0]     lp;
  logic [SW-1:0]      load_base;
  // text word state
  logic [TPW-1:0]     tp;
  logic [ENTRIES-1:0] alive;
  logic               replaced;
  logic               hit;
  logic [7:0]         ch_r;
  logic               last_r;
  // scan state
  logic [CW-1:0]      issue_idx;
  logic [SW-1:0]      scan_base;
  logic               pend;
  logic [EW-1:0]      cmp_idx;
  // output register
  logic               out_valid;
  logic [7:0]         out_char;
  logic               char_valid;
  logic               word_end;

  logic [LPW-1:0]     lp_inc;
  logic               chr_we;
  logic               len_we;
  logic [SW-1:0]      chr_waddr;
  logic [SW-1:0]      chr_raddr;
  logic [7:0]         chr_rd;
  logic [TPW-1:0]     len_rd;
  logic               kill;
  logic               match_end;

  assign lp_inc    = (lp <= LPW'(MAX_LEN)) ? lp + 1'b1 : lp;
  assign chr_we    = cmd.load && (lp < LPW'(MAX_LEN)) && (count < CW'(ENTRIES));
  assign len_we    = cmd.load && last && (lp_inc <= LPW'(MAX_LEN)) && (count < CW'(ENTRIES));
  assign chr_waddr = load_base + SW'(lp);
  assign chr_raddr = scan_base + SW'(tp);

  spr_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_chars (
    .clk   (clk),
    .we    (chr_we),
    .waddr (chr_waddr[AW-1:0]),
    .wdata (ch),
    .raddr (chr_raddr[AW-1:0]),
    .rdata (chr_rd)
  );

  spr_ram #(.WIDTH(TPW), .DEPTH(ENTRIES)) u_lengths (
    .clk   (clk),
    .we    (len_we),
    .waddr (count[EW-1:0]),
    .wdata (lp_inc[TPW-1:0]),
    .raddr (issue_idx[EW-1:0]),
    .rdata (len_rd)
  );

  // entry dies on a short length or a mismatch; a live entry ending here is a hit
  assign kill      = (len_rd <= tp) || (chr_rd != ch_r);
  assign match_end = ((TPW + 1)'(len_rd) == (TPW + 1)'(tp) + (TPW + 1)'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      lp        <= '0;
      load_base <= '0;
    end else if (cmd.clear) begin
      count     <= '0;
      lp        <= '0;
      load_base <= '0;
    end else if (cmd.load) begin
      if (last) begin
        lp <= '0;
        if (len_we) begin
          count     <= count + 1'b1;
          load_base <= load_base + SW'(MAX_LEN);
        end
      end else begin
        lp <= lp_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tp       <= '0;
      alive    <= '1;
      replaced <= 1'b0;
      pend     <= 1'b0;
    end else begin
      pend <= cmd.issue;
      if (len_we) begin
        alive[count[EW-1:0]] <= (tp == '0) && !replaced;
      end
      if (pend && alive[cmp_idx]) begin
        if (kill) alive[cmp_idx] <= 1'b0;
      end
      if (cmd.emit) begin
        if (last_r) begin
          tp       <= '0;
          replaced <= 1'b0;
          alive    <= '1;
        end else begin
          if (tp < TPW'(MAX_LEN)) tp <= tp + 1'b1;
          if (hit) replaced <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.text) begin
      ch_r      <= ch;
      last_r    <= last;
      hit       <= 1'b0;
      issue_idx <= '0;
      scan_base <= '0;
    end else begin
      if (cmd.issue) begin
        cmp_idx   <= issue_idx[EW-1:0];
        issue_idx <= issue_idx + 1'b1;
        scan_base <= scan_base + SW'(MAX_LEN);
      end
      if (pend && alive[cmp_idx] && !kill && match_end) begin
        hit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_char   <= replaced ? 8'd0 : ch_r;
      char_valid <= !replaced;
      word_end   <= last_r;
    end
  end

  assign dout.valid      = out_valid;
  assign dout.out_char   = out_char;
  assign dout.char_valid = char_valid;
  assign dout.word_end   = word_end;

  assign st.replaced  = replaced;
  assign st.need_scan = (tp < TPW'(MAX_LEN)) && (count != '0);
  assign st.more      = issue_idx < count;
  assign st.pend      = pend;
  assign st.out_free  = !out_valid || dout.ready;
endmodule
`default_nettype wire

[design/shortest_prefix_word_replacer.sv]
// Top level of the shortest dictionary prefix word replacer.
//
// Usage:
//   din carries one character beat: action (load dictionary char, process
//   text char, clear dictionary), ch and last (ends its word). dout carries
//   one beat per text character that is echoed, or a bare end marker
//   (char_valid low, word_end high) for a word cut short by a match.
//   Dictionary loads and clears give no beat. Once a
//   text word equals a stored word, its remaining characters are dropped
//   and its last character yields the end marker.
// Timing:
//   A text character is compared with the stored entries one per cycle,
//   through the read port of the character memory. No scan is needed
//   when the dictionary is empty, the word is already matched or the
//   position is past MAX_LEN. The next character is taken only after the
//   current one is done.
// Reset (rst, synchronous): empties the dictionary, restarts the text word
// and drops any pending output beat. Memory contents are not cleared.
// Stall: a finished beat holds in the output register while dout.ready is
// low; the block still accepts the next character, and a following result
// waits in the emit step until the register frees up.
`default_nettype none
module shortest_prefix_word_replacer #(
  parameter int ENTRIES = 16,
  parameter int MAX_LEN = 16
) (
  input wire logic  clk,
  input wire logic  rst,
  spr_in_if.sink    din,
  spr_out_if.source dout
);
  import spr_pkg::*;

  cmd_t    cmd;
  status_t st;
  logic    ready;

  // controller: sequences accept, entry scan and emit
  spr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (din.valid),
    .action   (din.action),
    .last     (din.last),
    .st       (st),
    .cmd      (cmd),
    .in_ready (ready)
  );

  assign din.ready = ready;

  // datapath: dictionary memories, per-entry candidate mask, output register
  spr_dp #(.ENTRIES(ENTRIES), .MAX_LEN(MAX_LEN)) u_dp (
    .clk  (clk),
    .rst  (rst),
    .ch   (din.ch),
    .last (din.last),
    .cmd  (cmd),
    .st   (st),
    .dout (dout)
  );
endmodule
`default_nettype wire
